// ===== src/psrd_pkg.sv =====
`timescale 1ns / 1ps
// psrd_pkg: phase codes, field widths and item structs for the patch stream
// run decoder. No dependencies.
package psrd_pkg;

   localparam int WORD_W  = 16;
   localparam int ADDR_W  = 8;
   localparam int COUNT_W = 15;
   localparam int PHASE_W = 2;

   // bit 15 of a count word marks a fill run
   localparam int FILL_BIT = 15;

   localparam logic [PHASE_W-1:0] PH_ADDR  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_COUNT = 2'd1;
   localparam logic [PHASE_W-1:0] PH_VALUE = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } in_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  reg_addr;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] repeat_res;
      logic               end_of_patch;
      logic               incomplete;
   } rsp_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               fill_mode;
   } status_type;

endpackage

// ===== src/psrd_if.sv =====
`timescale 1ns / 1ps
// psrd_req_if / psrd_rsp_if: valid-ready channels for input words and
// write commands. Depends on psrd_pkg.
interface psrd_req_if;
   logic                         valid;
   logic                         ready;
   logic [psrd_pkg::WORD_W-1:0]  word;
   logic                         last;

   modport source (output valid, output word, output last, input ready);
   modport sink   (input valid, input word, input last, output ready);
endinterface

interface psrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psrd_pkg::ADDR_W-1:0]   reg_addr;
   logic [psrd_pkg::WORD_W-1:0]   value;
   logic [psrd_pkg::COUNT_W-1:0]  repeat_res;
   logic                          end_of_patch;
   logic                          incomplete;

   modport source (output valid, output reg_addr, output value, output repeat_res,
                   output end_of_patch, output incomplete, input ready);
   modport sink   (input valid, input reg_addr, input value, input repeat_res,
                   input end_of_patch, input incomplete, output ready);
endinterface

// ===== src/psrd_in_stage.sv =====
`timescale 1ns / 1ps
// psrd_in_stage: input register for stream words.
// Depends on psrd_pkg and psrd_req_if.
module psrd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   psrd_req_if.sink              req_ch,
   input  logic                  advance,
   output logic                  item_valid,
   output psrd_pkg::in_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   psrd_pkg::in_item_type item_ff;
   logic                  take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.word <= req_ch.word;
         item_ff.last <= req_ch.last;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/psrd_decode.sv =====
`timescale 1ns / 1ps
// psrd_decode: record phase tracking and write command formation.
// Depends on psrd_pkg.
module psrd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  psrd_pkg::in_item_type  item,
   output logic                   emit,
   output psrd_pkg::rsp_item_type result,
   output psrd_pkg::status_type   status
);

   logic [psrd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [psrd_pkg::ADDR_W-1:0]  held_ff, held_in;
   logic [psrd_pkg::COUNT_W-1:0] left_ff, left_in;
   logic                         fill_ff, fill_in;

   logic [psrd_pkg::COUNT_W-1:0] rep;
   logic [psrd_pkg::WORD_W-1:0]  val;
   logic                         write_cmd;
   logic                         done;
   logic [psrd_pkg::COUNT_W-1:0] count;
   logic [psrd_pkg::COUNT_W-1:0] left_dec;

   assign count    = item.word[psrd_pkg::COUNT_W-1:0];
   assign left_dec = left_ff - {{(psrd_pkg::COUNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      left_in   = left_ff;
      fill_in   = fill_ff;
      rep       = '0;
      val       = '0;
      write_cmd = 1'b0;
      done      = 1'b0;
      unique case (phase_ff)
         psrd_pkg::PH_COUNT: begin
            fill_in = item.word[psrd_pkg::FILL_BIT];
            left_in = count;
            if (!item.word[psrd_pkg::FILL_BIT] && count == '0) begin
               phase_in = psrd_pkg::PH_ADDR;
               done     = 1'b1;
            end else begin
               phase_in = psrd_pkg::PH_VALUE;
            end
         end
         psrd_pkg::PH_VALUE: begin
            val = item.word;
            if (fill_ff) begin
               rep       = left_ff;
               write_cmd = (left_ff != '0);
               phase_in  = psrd_pkg::PH_ADDR;
               done      = 1'b1;
            end else begin
               rep       = {{(psrd_pkg::COUNT_W-1){1'b0}}, 1'b1};
               write_cmd = 1'b1;
               left_in   = left_dec;
               if (left_dec == '0) begin
                  phase_in = psrd_pkg::PH_ADDR;
                  done     = 1'b1;
               end
            end
         end
         default: begin
            // address word; the unused phase code lands here too
            held_in  = item.word[psrd_pkg::ADDR_W-1:0];
            phase_in = psrd_pkg::PH_COUNT;
         end
      endcase

      result.reg_addr     = held_in;
      result.value        = val;
      result.repeat_res   = rep;
      result.end_of_patch = item.last;
      result.incomplete   = 1'b0;
      emit                = write_cmd;
      if (item.last) begin
         // patch ends: back to reset state; flag a record cut short
         phase_in = psrd_pkg::PH_ADDR;
         held_in  = '0;
         left_in  = '0;
         fill_in  = 1'b0;
         if (!done) begin
            result.repeat_res = '0;
            result.incomplete = 1'b1;
            emit              = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= psrd_pkg::PH_ADDR;
         held_ff  <= '0;
         left_ff  <= '0;
         fill_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         left_ff  <= left_in;
         fill_ff  <= fill_in;
      end
   end

   assign status.phase     = phase_ff;
   assign status.fill_mode = fill_ff;

endmodule

// ===== src/psrd_out_stage.sv =====
`timescale 1ns / 1ps
// psrd_out_stage: result register driving the write command channel.
// Depends on psrd_pkg and psrd_rsp_if.
module psrd_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  psrd_pkg::rsp_item_type result,
   output logic                   free,
   psrd_rsp_if.source             rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   psrd_pkg::rsp_item_type data_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.reg_addr     = data_ff.reg_addr;
   assign rsp_ch.value        = data_ff.value;
   assign rsp_ch.repeat_res   = data_ff.repeat_res;
   assign rsp_ch.end_of_patch = data_ff.end_of_patch;
   assign rsp_ch.incomplete   = data_ff.incomplete;

endmodule

// ===== src/patch_stream_run_decoder.sv =====
`timescale 1ns / 1ps
// patch_stream_run_decoder: decodes address/count/value records of a patch
// word stream into register write commands.
// Depends on psrd_pkg, psrd_if, psrd_in_stage, psrd_decode, psrd_out_stage.
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   word[15:0], last
//   rsp_ch    out  valid/ready   reg_addr[7:0], value[15:0], repeat_res[14:0],
//                                end_of_patch, incomplete
//
// One word per cycle sustained while rsp_ch is ready; a word's command reaches
// rsp_ch via the input register, then decode into the result register. Address
// and count words and words closing a zero-count record give no item unless last
// cuts a record short. A stalled result register holds the decoder; the input register
// still takes one more word. Synchronous reset returns the decoder to expect-address.
module patch_stream_run_decoder (
   input  logic       clock,
   input  logic       reset,
   psrd_req_if.sink   req_ch,
   psrd_rsp_if.source rsp_ch
);

   logic                   item_valid;
   psrd_pkg::in_item_type  item;
   logic                   advance;
   logic                   emit;
   logic                   out_free;
   psrd_pkg::rsp_item_type result;
   psrd_pkg::status_type   status;

   assign advance = item_valid && out_free;

   psrd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   psrd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .emit    (emit),
      .result  (result),
      .status  (status)
   );

   psrd_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && emit),
      .result (result),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   // any word with last set leaves the decoder at a clean record start
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item.last |=> status.phase == psrd_pkg::PH_ADDR && !status.fill_mode)
      else $error("decoder state not cleared after last word");

   // a cut-short record is only reported at the end of a patch, with no repeat
   a_incomplete_form: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.incomplete |-> rsp_ch.end_of_patch && rsp_ch.repeat_res == '0)
      else $error("incomplete item malformed");

   // input side stalls only while a word is held back by the result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> item_valid && !out_free)
      else $error("input stalled without a blocked word");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: random and directed patch streams into patch_stream_run_decoder,
// write commands checked in order against a predictor of the record decoder.
// Depends on psrd_pkg, psrd_if and the patch_stream_run_decoder RTL.
module testbench;

   localparam int CLK_PERIOD  = 10;
   localparam int WORD_TARGET = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 10;

   // Tracks the decoder state and holds the write commands still to come.
   class write_scoreboard;
      psrd_pkg::rsp_item_type                 expected_writes[$];
      logic [psrd_pkg::PHASE_W-1:0]           phase;
      logic [psrd_pkg::ADDR_W-1:0]            held_addr;
      logic [psrd_pkg::COUNT_W-1:0]           words_left;
      logic                                   fill_mode;
      int                                     errors;

      function new();
         errors = 0;
         clear_decoder();
      endfunction

      function void clear_decoder();
         phase      = psrd_pkg::PH_ADDR;
         held_addr  = '0;
         words_left = '0;
         fill_mode  = 1'b0;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void note_word(logic [psrd_pkg::WORD_W-1:0] w, logic is_last);
         logic                         emit;
         logic                         done;
         logic [psrd_pkg::COUNT_W-1:0] rep;
         logic [psrd_pkg::WORD_W-1:0]  val;
         psrd_pkg::rsp_item_type       item;
         emit = 1'b0;
         done = 1'b0;
         rep  = '0;
         val  = '0;
         case (phase)
            psrd_pkg::PH_COUNT: begin
               fill_mode  = w[psrd_pkg::FILL_BIT];
               words_left = w[psrd_pkg::COUNT_W-1:0];
               if (!w[psrd_pkg::FILL_BIT] && w[psrd_pkg::COUNT_W-1:0] == '0) begin
                  phase = psrd_pkg::PH_ADDR;
                  done  = 1'b1;
               end else begin
                  phase = psrd_pkg::PH_VALUE;
               end
            end
            psrd_pkg::PH_VALUE: begin
               val = w;
               if (fill_mode) begin
                  rep   = words_left;
                  emit  = (rep != '0);
                  phase = psrd_pkg::PH_ADDR;
                  done  = 1'b1;
               end else begin
                  rep        = {{(psrd_pkg::COUNT_W-1){1'b0}}, 1'b1};
                  emit       = 1'b1;
                  words_left = words_left - 1'b1;
                  if (words_left == '0) begin
                     phase = psrd_pkg::PH_ADDR;
                     done  = 1'b1;
                  end
               end
            end
            default: begin
               // unused phase code falls back to expect-address
               held_addr = w[psrd_pkg::ADDR_W-1:0];
               phase     = psrd_pkg::PH_COUNT;
            end
         endcase

         item.reg_addr     = held_addr;
         item.value        = val;
         item.repeat_res   = rep;
         item.end_of_patch = is_last;
         item.incomplete   = 1'b0;
         if (is_last) begin
            clear_decoder();
            if (!done) begin
               // stream cut inside a record
               item.repeat_res = '0;
               item.incomplete = 1'b1;
               expected_writes.push_back(item);
            end else if (emit) begin
               expected_writes.push_back(item);
            end
         end else if (emit) begin
            expected_writes.push_back(item);
         end
      endfunction

      function void check_write(psrd_pkg::rsp_item_type got);
         psrd_pkg::rsp_item_type exp;
         if (expected_writes.size() == 0) begin
            errors++;
            $display("%0t: unexpected write: addr=%h value=%h repeat=%h eop=%b inc=%b",
                     $time, got.reg_addr, got.value, got.repeat_res,
                     got.end_of_patch, got.incomplete);
         end else begin
            exp = expected_writes.pop_front();
            if (got !== exp) begin
               errors++;
               $display("%0t: write mismatch: expected addr=%h value=%h repeat=%h eop=%b inc=%b",
                        $time, exp.reg_addr, exp.value, exp.repeat_res,
                        exp.end_of_patch, exp.incomplete);
               $display("%0t:                 actual   addr=%h value=%h repeat=%h eop=%b inc=%b",
                        $time, got.reg_addr, got.value, got.repeat_res,
                        got.end_of_patch, got.incomplete);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   words_sent;
   int   req_mode;
   int   rsp_mode;

   write_scoreboard sb = new();

   psrd_req_if req_ch ();
   psrd_rsp_if rsp_ch ();

   patch_stream_run_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("patch_stream_run_decoder test failed");
         $finish;
      end
   end

   // mode 0 never idles; otherwise mostly short gaps and now and then a long one
   function automatic int pick_gap(int mode);
      int r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_word(req_ch.word, req_ch.last);
   end

   always @(posedge clock) begin
      psrd_pkg::rsp_item_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.reg_addr     = rsp_ch.reg_addr;
         got.value        = rsp_ch.value;
         got.repeat_res   = rsp_ch.repeat_res;
         got.end_of_patch = rsp_ch.end_of_patch;
         got.incomplete   = rsp_ch.incomplete;
         sb.check_write(got);
      end
   end

   // result side back-pressure; the stall style is picked at random among three modes
   initial begin
      int hold;
      int tick;
      hold        = 0;
      tick        = 0;
      rsp_mode    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 256 == 0) rsp_mode = $urandom_range(0, 2);
         if (hold > 0) begin
            rsp_ch.ready = 1'b0;
            hold--;
         end else begin
            rsp_ch.ready = 1'b1;
            hold = pick_gap(rsp_mode);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_word(input logic [psrd_pkg::WORD_W-1:0] w, input logic is_last);
      int gap;
      gap = pick_gap(req_mode);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.word  = w;
      req_ch.last  = is_last;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // mostly well-formed records; some noise and some streams cut mid-record
   task automatic send_random_patch();
      logic [psrd_pkg::WORD_W-1:0] words[$];
      logic [psrd_pkg::WORD_W-1:0] cw;
      int                          recs;
      int                          n;
      int                          kind;
      int                          cut;
      bit                          open_run;
      open_run = 1'b0;
      req_mode = $urandom_range(0, 3) == 0 ? 0 : 1;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) words.push_back(psrd_pkg::WORD_W'($urandom));
      end else begin
         recs = $urandom_range(1, 4);
         for (int r = 0; r < recs && !open_run; r++) begin
            words.push_back(psrd_pkg::WORD_W'($urandom));
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
               words.push_back(psrd_pkg::WORD_W'(n));
               repeat (n) words.push_back(psrd_pkg::WORD_W'($urandom));
            end else if (kind < 85) begin
               cw = {1'b1, psrd_pkg::COUNT_W'($urandom)};
               if ($urandom_range(0, 7) == 0) cw[psrd_pkg::COUNT_W-1:0] = '0;
               words.push_back(cw);
               words.push_back(psrd_pkg::WORD_W'($urandom));
            end else if (kind < 93) begin
               // zero-count copy run
               words.push_back('0);
            end else begin
               // long copy run that the stream cuts short
               cw = {1'b0, psrd_pkg::COUNT_W'($urandom_range(8, 32767))};
               words.push_back(cw);
               n = $urandom_range(0, 4);
               repeat (n) words.push_back(psrd_pkg::WORD_W'($urandom));
               open_run = 1'b1;
            end
         end
      end
      cut = words.size() - 1;
      if (!open_run && $urandom_range(0, 4) == 0) cut = $urandom_range(0, words.size() - 1);
      for (int i = 0; i <= cut; i++) push_word(words[i], i == cut);
   endtask

   initial begin
      bit paused;
      int waited;
      paused       = 1'b0;
      cycle_count  = 0;
      words_sent   = 0;
      req_mode     = 0;
      req_ch.valid = 1'b0;
      req_ch.word  = '0;
      req_ch.last  = 1'b0;
      reset        = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // copy run over the full address and value range
      push_word(16'hFFFF, 0); push_word(16'h0002, 0);
      push_word(16'h0000, 0); push_word(16'hFFFF, 0);
      // fill run with the largest repeat
      push_word(16'h1200, 0); push_word(16'hFFFF, 0); push_word(16'hA5A5, 0);
      // zero-count copy, then zero-count fill
      push_word(16'h0034, 0); push_word(16'h0000, 0);
      req_mode = 1;
      push_word(16'h0056, 0); push_word(16'h8000, 0); push_word(16'h1234, 0);
      // last on an address word
      push_word(16'hAB77, 1);
      // last on a copy value that is not the run's final one
      push_word(16'h0001, 0); push_word(16'h7FFF, 0); push_word(16'hBEEF, 1);
      // last on a count word that announces values
      push_word(16'h5A02, 0); push_word(16'h0003, 1);
      // last on a zero-count copy word: no write
      push_word(16'h00C3, 0); push_word(16'h0000, 1);
      // last on a fill value, then on a zero-count fill value
      push_word(16'h0010, 0); push_word(16'h8005, 0); push_word(16'h5555, 1);
      push_word(16'h0020, 0); push_word(16'h8000, 0); push_word(16'h7777, 1);
      // last on the final copy value
      push_word(16'h0030, 0); push_word(16'h0001, 0); push_word(16'hAAAA, 1);

      while (words_sent < WORD_TARGET) begin
         if (!paused && words_sent >= WORD_TARGET / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         send_random_patch();
      end

      wait_drained();
      waited = 0;
      while (waited < DRAIN_WAIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("patch_stream_run_decoder test passed");
      end else begin
         $display("patch_stream_run_decoder test failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
src/psrd_pkg.sv
src/psrd_if.sv
src/psrd_in_stage.sv
src/psrd_decode.sv
src/psrd_out_stage.sv
src/patch_stream_run_decoder.sv
sim/testbench.sv
